// File: src/epr_pkg.sv
package epr_pkg;

   // Field widths of the configuration registers
   localparam int ATTEMPT_W  = 6;
   localparam int US_W       = 16;
   localparam int TRIG_W     = 8;
   localparam int HALF_W     = 13;

   // Result field widths
   localparam int AVG_W      = 16;
   localparam int DIST_W     = 20;
   localparam int GOOD_W     = 6;
   localparam int PROD_W     = AVG_W + HALF_W;

   // Q8 cm/ms times us gives 1000x the Q8 distance in cm
   localparam int SCALE_DIV  = 1000;

   // floor(x / 1000) as (x * RECIP_MULT) >> RECIP_SHIFT, exact for x below 2^29
   localparam int                 RECIP_W     = 29;
   localparam int                 RECIP_SHIFT = 38;
   localparam logic [RECIP_W-1:0] RECIP_MULT  = 29'd274877907;
   localparam int                 SCALED_W    = PROD_W + RECIP_W;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [ATTEMPT_W-1:0] RST_ATTEMPT_COUNT = 6'd30;
   localparam logic [US_W-1:0]      RST_MIN_ECHO      = 16'd200;
   localparam logic [US_W-1:0]      RST_SETTLE_GAP    = 16'd1000;
   localparam logic [TRIG_W-1:0]    RST_TRIGGER_WIDTH = 8'd20;
   localparam logic [US_W-1:0]      RST_RISE_TIMEOUT  = 16'd50000;
   localparam logic [HALF_W-1:0]    RST_HALF_SPEED    = 13'd4390;
   localparam logic [US_W-1:0]      RST_FALLBACK      = 16'd140;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTEMPT_COUNT  = 3'd0,
      CSR_MIN_ECHO       = 3'd1,
      CSR_SETTLE_GAP     = 3'd2,
      CSR_TRIGGER_WIDTH  = 3'd3,
      CSR_RISE_TIMEOUT   = 3'd4,
      CSR_HALF_SPEED     = 3'd5,
      CSR_FALLBACK       = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [ATTEMPT_W-1:0] attempt_count;
      logic [US_W-1:0]      min_echo_us;
      logic [US_W-1:0]      settle_gap_us;
      logic [TRIG_W-1:0]    trigger_width_us;
      logic [US_W-1:0]      rise_timeout_us;
      logic [HALF_W-1:0]    half_speed_q8;
      logic [US_W-1:0]      fallback_us;
   } cfg_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SETTLE = 3'd1,
      PH_TRIG   = 3'd2,
      PH_RISE   = 3'd3,
      PH_HIGH   = 3'd4
   } phase_type;

   // Microcode
   localparam int STEP_W = 4;

   typedef enum logic [STEP_W-1:0] {
      ST_WAIT      = 4'd0,
      ST_CHK       = 4'd1,
      ST_LOAD_SUM  = 4'd2,
      ST_DIV_AVG   = 4'd3,
      ST_AVG_SEL   = 4'd4,
      ST_MUL       = 4'd5,
      ST_SCALE     = 4'd6,
      ST_STORE     = 4'd7,
      ST_EMIT      = 4'd8
   } step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_TICK,
      OP_DIV_LOAD_SUM,
      OP_DIV_STEP,
      OP_AVG_SEL,
      OP_MUL,
      OP_SCALE,
      OP_STORE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_IN_ACC,
      C_NOT_FIN,
      C_DIV_MORE,
      C_OUT_FREE
   } cond_type;

   // One control word: operation, jump condition and target, stall when false
   typedef struct packed {
      op_type   op;
      cond_type cond;
      logic     stall;
      step_type target;
   } ctrl_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic in_acc;
      logic not_fin;
      logic div_more;
      logic out_free;
   } flags_type;

   // Tick unit status
   typedef struct packed {
      logic trigger;
      logic busy;
      logic finish;
   } tick_stat_type;

endpackage

// File: src/epr_req_if.sv
interface epr_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic echo_level;

   modport source (output valid, output start_req, output echo_level, input ready);
   modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

// File: src/epr_rsp_if.sv
interface epr_rsp_if
   import epr_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              trigger_level;
   logic              busy_res;
   logic              done_res;
   logic [AVG_W-1:0]  average_us;
   logic [DIST_W-1:0] distance_q8;
   logic [GOOD_W-1:0] good_count;

   modport source (output valid, output trigger_level, output busy_res, output done_res,
                   output average_us, output distance_q8, output good_count, input ready);
   modport sink (input valid, input trigger_level, input busy_res, input done_res,
                 input average_us, input distance_q8, input good_count, output ready);
endinterface

// File: src/echo_pulse_ranging_averager_core.sv
// Echo pulse ranging averager.
// req_ch carries one word per microsecond tick: start_req and the sampled
// echo_level. rsp_ch returns exactly one word per accepted tick: trigger
// level, busy, done, the last stored average and distance, and the accepted
// count. csr_we/csr_index/csr_wdata write the seven setup registers; write
// them only while no measurement runs.
// Sequencing: an ordinary tick is accepted at the wait step, passes the
// check step and the emit step, which loads the output register, and the
// next word is accepted once the sequencer is back at the wait step. The
// tick that ends a measurement runs the averaging program: a divider load,
// one serial divide of one quotient bit per cycle, the average select, then
// the Q8 scaling multiply and a reciprocal multiply for the divide by 1000,
// and a store of the results before the emit step.
// A new tick word is accepted while the previous result still waits in the
// output register; if rsp_ch stalls, the sequencer holds at its emit step
// and takes no further tick until the held word leaves.
// Reset (synchronous) puts the block idle with zero results and default
// register values; no output word is pending after reset.
module echo_pulse_ranging_averager_core
   import epr_pkg::*;
#(
   parameter int TIMER_BITS   = 16,
   parameter int ATTEMPT_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   epr_req_if.sink               req_ch,
   epr_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W = TIMER_BITS + ATTEMPT_BITS;
   localparam int DVD_W = (SUM_W > AVG_W) ? SUM_W : AVG_W + 1;
   localparam int DVS_W = ATTEMPT_BITS;
   localparam int GM_W  = (ATTEMPT_BITS > GOOD_W) ? ATTEMPT_BITS : GOOD_W;

   cfg_type                 cfg_ff;
   ctrl_type                ctrl;
   step_type                step;
   flags_type               flags;
   tick_stat_type           stat;
   logic [ATTEMPT_BITS-1:0] accepted;
   logic [SUM_W-1:0]        width_sum;
   logic                    req_acc;
   logic                    emit_load;
   logic                    div_load;
   logic [DVD_W-1:0]        div_dividend, quotient;
   logic                    div_more;
   logic [GM_W-1:0]         good_ext;

   logic [AVG_W-1:0]        avg_ff, avg_in;
   logic [PROD_W-1:0]       prod_ff;
   logic [SCALED_W-1:0]     scaled_ff;
   logic [AVG_W-1:0]        last_avg_ff;
   logic [DIST_W-1:0]       last_dist_ff, dist_q;

   logic                    rsp_valid_ff;
   logic                    rsp_trig_ff, rsp_busy_ff, rsp_done_ff;
   logic [AVG_W-1:0]        rsp_avg_ff;
   logic [DIST_W-1:0]       rsp_dist_ff;
   logic [GOOD_W-1:0]       rsp_good_ff;

   // Setup registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attempt_count    <= RST_ATTEMPT_COUNT;
         cfg_ff.min_echo_us      <= RST_MIN_ECHO;
         cfg_ff.settle_gap_us    <= RST_SETTLE_GAP;
         cfg_ff.trigger_width_us <= RST_TRIGGER_WIDTH;
         cfg_ff.rise_timeout_us  <= RST_RISE_TIMEOUT;
         cfg_ff.half_speed_q8    <= RST_HALF_SPEED;
         cfg_ff.fallback_us      <= RST_FALLBACK;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ATTEMPT_COUNT: cfg_ff.attempt_count    <= csr_wdata[ATTEMPT_W-1:0];
            CSR_MIN_ECHO:      cfg_ff.min_echo_us      <= csr_wdata[US_W-1:0];
            CSR_SETTLE_GAP:    cfg_ff.settle_gap_us    <= csr_wdata[US_W-1:0];
            CSR_TRIGGER_WIDTH: cfg_ff.trigger_width_us <= csr_wdata[TRIG_W-1:0];
            CSR_RISE_TIMEOUT:  cfg_ff.rise_timeout_us  <= csr_wdata[US_W-1:0];
            CSR_HALF_SPEED:    cfg_ff.half_speed_q8    <= csr_wdata[HALF_W-1:0];
            CSR_FALLBACK:      cfg_ff.fallback_us      <= csr_wdata[US_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   assign req_ch.ready   = (ctrl.op == OP_TICK);
   assign req_acc        = req_ch.valid && req_ch.ready;
   assign flags.in_acc   = req_acc;
   assign flags.not_fin  = !stat.finish;
   assign flags.div_more = div_more;
   assign flags.out_free = !rsp_valid_ff || rsp_ch.ready;

   epr_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .step  (step)
   );

   // Tick unit: phases, timers, attempt counts
   epr_tick #(
      .TIMER_BITS   (TIMER_BITS),
      .ATTEMPT_BITS (ATTEMPT_BITS)
   ) u_tick (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (req_acc),
      .start_req  (req_ch.start_req),
      .echo_level (req_ch.echo_level),
      .cfg        (cfg_ff),
      .stat       (stat),
      .accepted   (accepted),
      .width_sum  (width_sum)
   );

   // Serial divider: width sum by accepted count
   assign div_load     = (ctrl.op == OP_DIV_LOAD_SUM);
   assign div_dividend = DVD_W'(width_sum);

   epr_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .step     (ctrl.op == OP_DIV_STEP),
      .dividend (div_dividend),
      .divisor  (accepted),
      .quotient (quotient),
      .more     (div_more)
   );

   // Average select with saturation, fallback when nothing was accepted
   always_comb begin
      if (accepted == '0) begin
         avg_in = cfg_ff.fallback_us;
      end else if (|quotient[DVD_W-1:AVG_W]) begin
         avg_in = '1;
      end else begin
         avg_in = quotient[AVG_W-1:0];
      end
   end

   // Distance: product over 1000 by reciprocal multiply, always fits 20 bits
   assign dist_q = scaled_ff[RECIP_SHIFT +: DIST_W];

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_AVG_SEL) begin
         avg_ff <= avg_in;
      end
      if (ctrl.op == OP_MUL) begin
         prod_ff <= PROD_W'(avg_ff) * PROD_W'(cfg_ff.half_speed_q8);
      end
      if (ctrl.op == OP_SCALE) begin
         scaled_ff <= SCALED_W'(prod_ff) * SCALED_W'(RECIP_MULT);
      end
   end

   // Stored results
   always_ff @(posedge clock) begin
      if (reset) begin
         last_avg_ff  <= '0;
         last_dist_ff <= '0;
      end else if (ctrl.op == OP_STORE) begin
         last_avg_ff  <= avg_ff;
         last_dist_ff <= dist_q;
      end
   end

   // Output register
   assign emit_load = (ctrl.op == OP_EMIT) && flags.out_free;
   assign good_ext  = GM_W'(accepted);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_trig_ff <= stat.trigger;
         rsp_busy_ff <= stat.busy;
         rsp_done_ff <= stat.finish;
         rsp_avg_ff  <= last_avg_ff;
         rsp_dist_ff <= last_dist_ff;
         rsp_good_ff <= good_ext[GOOD_W-1:0];
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.trigger_level = rsp_trig_ff;
   assign rsp_ch.busy_res      = rsp_busy_ff;
   assign rsp_ch.done_res      = rsp_done_ff;
   assign rsp_ch.average_us    = rsp_avg_ff;
   assign rsp_ch.distance_q8   = rsp_dist_ff;
   assign rsp_ch.good_count    = rsp_good_ff;

`ifndef SYNTHESIS
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (step == ST_CHK))
      else $error("accepted tick did not move sequencer to check step");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      stat.finish |-> !stat.busy)
      else $error("measurement finished while tick unit still busy");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> rsp_valid_ff)
      else $error("emitted word not presented on response channel");
`endif

endmodule

// File: src/epr_useq.sv
module epr_useq
   import epr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl,
   output step_type  step
);

   step_type step_ff, step_in;
   logic     cond_true;

   // Microcode ROM
   always_comb begin
      unique case (step_ff)
         ST_WAIT:      ctrl = '{OP_TICK,          C_IN_ACC,   1'b1, ST_CHK};
         ST_CHK:       ctrl = '{OP_NOP,           C_NOT_FIN,  1'b0, ST_EMIT};
         ST_LOAD_SUM:  ctrl = '{OP_DIV_LOAD_SUM,  C_NEVER,    1'b0, ST_WAIT};
         ST_DIV_AVG:   ctrl = '{OP_DIV_STEP,      C_DIV_MORE, 1'b0, ST_DIV_AVG};
         ST_AVG_SEL:   ctrl = '{OP_AVG_SEL,       C_NEVER,    1'b0, ST_WAIT};
         ST_MUL:       ctrl = '{OP_MUL,           C_NEVER,    1'b0, ST_WAIT};
         ST_SCALE:     ctrl = '{OP_SCALE,         C_NEVER,    1'b0, ST_WAIT};
         ST_STORE:     ctrl = '{OP_STORE,         C_NEVER,    1'b0, ST_WAIT};
         ST_EMIT:      ctrl = '{OP_EMIT,          C_OUT_FREE, 1'b1, ST_WAIT};
         default:      ctrl = '{OP_NOP,           C_ALWAYS,   1'b0, ST_WAIT};
      endcase
   end

   // Condition select
   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:    cond_true = 1'b0;
         C_ALWAYS:   cond_true = 1'b1;
         C_IN_ACC:   cond_true = flags.in_acc;
         C_NOT_FIN:  cond_true = flags.not_fin;
         C_DIV_MORE: cond_true = flags.div_more;
         C_OUT_FREE: cond_true = flags.out_free;
         default:    cond_true = 1'b1;
      endcase
   end

   // Next step: jump, stall or fall through
   always_comb begin
      if (cond_true) begin
         step_in = ctrl.target;
      end else if (ctrl.stall) begin
         step_in = step_ff;
      end else begin
         step_in = step_type'(step_ff + STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

// File: src/epr_tick.sv
module epr_tick
   import epr_pkg::*;
#(
   parameter int TIMER_BITS   = 16,
   parameter int ATTEMPT_BITS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               tick_en,
   input  logic                               start_req,
   input  logic                               echo_level,
   input  cfg_type                            cfg,
   output tick_stat_type                      stat,
   output logic [ATTEMPT_BITS-1:0]            accepted,
   output logic [TIMER_BITS+ATTEMPT_BITS-1:0] width_sum
);

   localparam int SUM_W = TIMER_BITS + ATTEMPT_BITS;
   localparam int CMP_W = (TIMER_BITS > US_W) ? TIMER_BITS : US_W;
   localparam int AM_W  = (ATTEMPT_BITS > ATTEMPT_W) ? ATTEMPT_BITS : ATTEMPT_W;
   localparam logic [TIMER_BITS-1:0] TMAX = '1;

   phase_type               phase_ff, phase_in;
   logic [TIMER_BITS-1:0]   timer_ff, timer_in, timer_up;
   logic [ATTEMPT_BITS-1:0] att_ff, att_in, att_next, target;
   logic [ATTEMPT_BITS-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic                    fin_ff, fin_in;
   logic [AM_W-1:0]         count_ext;
   logic                    timer_sat;
   logic                    settle_hit, trig_hit, rise_hit, long_enough;

   // Saturating phase timer and limit checks
   assign timer_up   = (timer_ff == TMAX) ? TMAX : timer_ff + TIMER_BITS'(1);
   assign timer_sat  = (timer_up == TMAX);
   assign settle_hit = (CMP_W'(timer_up) >= CMP_W'(cfg.settle_gap_us)) || timer_sat;
   assign trig_hit   = (CMP_W'(timer_up) >= CMP_W'(cfg.trigger_width_us)) || timer_sat;
   assign rise_hit   = (CMP_W'(timer_up) >= CMP_W'(cfg.rise_timeout_us)) || timer_sat;
   assign long_enough = CMP_W'(timer_ff) >= CMP_W'(cfg.min_echo_us);

   // Attempt target, taken modulo the counter range
   assign count_ext = AM_W'(cfg.attempt_count);
   assign target    = count_ext[ATTEMPT_BITS-1:0];
   assign att_next  = att_ff + ATTEMPT_BITS'(1);

   // Per-tick phase update
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      att_in   = att_ff;
      acc_in   = acc_ff;
      sum_in   = sum_ff;
      fin_in   = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               att_in   = '0;
               acc_in   = '0;
               sum_in   = '0;
               timer_in = '0;
               phase_in = PH_SETTLE;
            end
         end
         PH_SETTLE: begin
            timer_in = timer_up;
            if (settle_hit) begin
               timer_in = '0;
               phase_in = PH_TRIG;
            end
         end
         PH_TRIG: begin
            timer_in = timer_up;
            if (trig_hit) begin
               timer_in = '0;
               phase_in = PH_RISE;
            end
         end
         PH_RISE: begin
            if (echo_level) begin
               timer_in = TIMER_BITS'(1);
               phase_in = PH_HIGH;
            end else begin
               timer_in = timer_up;
               if (rise_hit) begin
                  att_in   = att_next;
                  timer_in = '0;
                  if (target != '0 && att_next < target) begin
                     phase_in = PH_SETTLE;
                  end else begin
                     phase_in = PH_IDLE;
                     fin_in   = 1'b1;
                  end
               end
            end
         end
         PH_HIGH: begin
            if (echo_level) begin
               timer_in = timer_up;
            end else begin
               if (long_enough) begin
                  acc_in = acc_ff + ATTEMPT_BITS'(1);
                  sum_in = sum_ff + SUM_W'(timer_ff);
               end
               att_in   = att_next;
               timer_in = '0;
               if (target != '0 && att_next < target) begin
                  phase_in = PH_SETTLE;
               end else begin
                  phase_in = PH_IDLE;
                  fin_in   = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            timer_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         att_ff   <= '0;
         acc_ff   <= '0;
         sum_ff   <= '0;
         fin_ff   <= 1'b0;
      end else if (tick_en) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         att_ff   <= att_in;
         acc_ff   <= acc_in;
         sum_ff   <= sum_in;
         fin_ff   <= fin_in;
      end
   end

   assign stat.trigger = (phase_ff == PH_TRIG);
   assign stat.busy    = (phase_ff != PH_IDLE);
   assign stat.finish  = fin_ff;
   assign accepted     = acc_ff;
   assign width_sum    = sum_ff;

endmodule

// File: src/epr_div.sv
module epr_div #(
   parameter int DVD_W = 29,
   parameter int DVS_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             step,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic             more
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W:0]   rem_ff, rem_in, rem_sh;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_sh = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_W'(DVD_W);
      end else if (step) begin
         rem_in = fits ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // Step counter is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (load) begin
         dvs_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign more     = (cnt_ff != CNT_W'(1));

endmodule
